// File: hw/rtl/wfo_pkg.sv
// ----------------------------------------------------------------------------
// wfo_pkg
// Shared constants and controller/datapath interface types for the waveform
// overview min/max/RMS block.
// ----------------------------------------------------------------------------
package wfo_pkg;

   localparam int BINS_DEFAULT = 256;

   localparam int SAMPLE_W   = 24;
   localparam int MINMAX_W   = 25;
   localparam int LEVEL_W    = 24;
   localparam int INDEX_W    = 8;
   localparam int FRAME_W    = 32;
   localparam int CHAN_W     = 7;
   localparam int CHPOS_W    = 6;
   localparam int SUM_W      = 64;
   localparam int COUNT_W    = 38;
   localparam int SQ_W       = 34;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 24;
   localparam int STEP_W     = 7;

   localparam logic [CHAN_W-1:0] MAX_CHANNELS = 7'd64;
   localparam logic signed [MINMAX_W-1:0] Q_ONE     = 25'sd8388608;
   localparam logic signed [MINMAX_W-1:0] Q_NEG_ONE = -25'sd8388608;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

   typedef struct packed {
      logic capture;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic store_rms;
      logic clip_phase;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic emit;
      logic last;
      logic out_busy;
   } status_type;

endpackage

// File: hw/rtl/wfo_ctrl.sv
// ----------------------------------------------------------------------------
// wfo_ctrl
// Sequencer: item capture, accumulate, and for a bin-closing item shared divide
// and square root passes for the bin RMS and, on the final bin, the clip RMS.
// ----------------------------------------------------------------------------
module wfo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wfo_pkg::status_type status,
   output wfo_pkg::cmd_type    cmd
);
   import wfo_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ACC   = 8'b0000_0010,
      ST_DLOAD = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_SLOAD = 8'b0001_0000,
      ST_SQRT  = 8'b0010_0000,
      ST_STORE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic clip_ff, clip_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clip_in  = clip_ff;
      cmd      = '0;
      cmd.clip_phase = clip_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = (status.active && status.emit) ? ST_DLOAD : ST_IDLE;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_SLOAD;
         end
         ST_SLOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store_rms = 1'b1;
            if (!clip_ff && status.last) begin
               clip_in  = 1'b1;
               state_in = ST_DLOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               clip_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         clip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clip_ff  <= clip_in;
      end
   end

endmodule

// File: hw/rtl/wfo_datapath.sv
// ----------------------------------------------------------------------------
// wfo_datapath
// Config registers, bin and clip accumulators, position tracking, a shared
// radix-2 divider and bit-serial square root, and the result register.
// ----------------------------------------------------------------------------
module wfo_datapath #(
   parameter int BINS = wfo_pkg::BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [wfo_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  csr_write,
   input  logic [wfo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wfo_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wfo_pkg::cmd_type                      cmd,
   output wfo_pkg::status_type                   status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wfo_pkg::INDEX_W-1:0]           rsp_bin_index,
   output logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_min,
   output logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_max,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_bin_rms,
   output logic                                  rsp_last_bin,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_peak,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_rms
);
   import wfo_pkg::*;

   localparam int LOG_BINS = $clog2(BINS);
   localparam int CB_W     = LOG_BINS + 1;
   localparam int PROD_W   = CB_W + FRAME_W;
   localparam logic [FRAME_W-1:0] BINS_F = FRAME_W'(BINS);

   // config
   logic [FRAME_W-1:0] fc_ff;
   logic [CHAN_W-1:0]  cc_ff;
   logic [CHAN_W-1:0]  ch_eff;
   logic               cfg_hit;
   logic [FRAME_W-1:0] fc_new;

   // accumulators and positions
   logic signed [MINMAX_W-1:0] x_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [LEVEL_W-1:0]         mag_ff;
   logic [CHPOS_W-1:0]         chpos_ff;
   logic [FRAME_W-1:0]         fpos_ff;
   logic [CB_W-1:0]            cb_ff;
   logic [FRAME_W-1:0]         bend_ff;
   logic signed [MINMAX_W-1:0] min_ff, max_ff;
   logic [SUM_W-1:0]           bsum_ff, csum_ff;
   logic [COUNT_W-1:0]         bcnt_ff;
   logic [LEVEL_W-1:0]         peak_ff;
   logic                       last_ff;

   // arithmetic unit
   logic [COUNT_W-1:0]   rem_ff, rem_in, dvs_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [COUNT_W:0]     div_t;
   logic                 div_ge;
   logic [32:0]          mean;
   logic [47:0]          rad_ff;
   logic [LEVEL_W-1:0]   root_ff;
   logic [25:0]          srem_ff, srem_in;
   logic [27:0]          sq_rem2, sq_trial;
   logic                 sq_ge;
   logic [LEVEL_W-1:0]   brms_ff, crms_ff;

   // output register
   logic                       ov_ff;
   logic [INDEX_W-1:0]         oidx_ff;
   logic signed [MINMAX_W-1:0] omin_ff, omax_ff;
   logic [LEVEL_W-1:0]         orms_ff, opeak_ff, ocrms_ff;
   logic                       olast_ff;

   logic [SAMPLE_W:0]   mag_full;
   logic [SUM_W:0]      bsum_add, csum_add;
   logic [CHPOS_W:0]    chpos_next;
   logic                frame_wrap;
   logic [FRAME_W-1:0]  fpos_next;
   logic [CB_W-1:0]     cb_next;
   logic [PROD_W-1:0]   bend_prod;
   logic [FRAME_W-1:0]  bend_next;
   logic [FRAME_W-1:0]  nb;
   logic [31:0]         cb_ext;
   logic [CHAN_W+FRAME_W-1:0] clip_items;

   assign ch_eff = (cc_ff == '0) ? CHAN_W'(1) :
                   (cc_ff > MAX_CHANNELS) ? MAX_CHANNELS : cc_ff;
   assign cfg_hit = csr_write &&
                    (csr_index == REG_FRAME_COUNT || csr_index == REG_CHANNEL_COUNT);
   assign fc_new  = (csr_index == REG_FRAME_COUNT) ? csr_wdata : fc_ff;

   assign mag_full   = req_sample[SAMPLE_W-1] ? -{req_sample[SAMPLE_W-1], req_sample}
                                              : {1'b0, req_sample};
   assign bsum_add   = {1'b0, bsum_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_ff};
   assign csum_add   = {1'b0, csum_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_ff};
   assign chpos_next = {1'b0, chpos_ff} + 1'b1;
   assign frame_wrap = (chpos_next >= ch_eff);
   assign fpos_next  = fpos_ff + 1'b1;
   assign nb         = (fc_ff < BINS_F) ? fc_ff : BINS_F;
   assign cb_next    = cb_ff + 1'b1;
   assign bend_prod  = PROD_W'(cb_next + 1'b1) * PROD_W'(fc_ff);
   assign bend_next  = (fc_ff >= BINS_F) ? FRAME_W'(bend_prod >> LOG_BINS)
                                         : FRAME_W'(cb_next + 1'b1);
   assign clip_items = CHAN_W'(ch_eff) * (CHAN_W+FRAME_W)'(fc_ff);
   assign cb_ext     = 32'(cb_ff);

   assign status.active   = (fc_ff != '0);
   assign status.emit     = frame_wrap && (fpos_next == bend_ff);
   assign status.last     = last_ff;
   assign status.out_busy = ov_ff && !rsp_ready;

   assign div_t  = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge = (div_t >= {1'b0, dvs_ff});
   assign rem_in = div_ge ? COUNT_W'(div_t - {1'b0, dvs_ff}) : div_t[COUNT_W-1:0];
   assign mean   = (quo_ff > 64'h1_0000_0000) ? 33'h1_0000_0000 : quo_ff[32:0];

   assign sq_rem2  = {srem_ff, rad_ff[47:46]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_rem2 >= sq_trial);
   assign srem_in  = sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= MINMAX_W'(req_sample);
         mag_ff <= mag_full[LEVEL_W-1:0];
         sq_ff  <= SQ_W'((48'(mag_full) * 48'(mag_full)) >> 14);
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= cmd.clip_phase ? csum_ff : bsum_ff;
         dvs_ff <= cmd.clip_phase ? COUNT_W'(clip_items) : bcnt_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], div_ge};
      end
      if (cmd.sqrt_load) begin
         rad_ff  <= {1'b0, mean, 14'b0};
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[45:0], 2'b00};
         root_ff <= {root_ff[LEVEL_W-2:0], sq_ge};
         srem_ff <= srem_in;
      end
      if (cmd.store_rms) begin
         if (cmd.clip_phase) crms_ff <= root_ff;
         else brms_ff <= root_ff;
      end
      if (cmd.load_out) begin
         oidx_ff  <= cb_ext[INDEX_W-1:0];
         omin_ff  <= min_ff;
         omax_ff  <= max_ff;
         orms_ff  <= brms_ff;
         olast_ff <= last_ff;
         opeak_ff <= last_ff ? peak_ff : '0;
         ocrms_ff <= last_ff ? crms_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff    <= FRAME_W'(1);
         cc_ff    <= CHAN_W'(1);
         chpos_ff <= '0;
         fpos_ff  <= '0;
         cb_ff    <= '0;
         bend_ff  <= FRAME_W'(1);
         min_ff   <= Q_ONE;
         max_ff   <= Q_NEG_ONE;
         bsum_ff  <= '0;
         csum_ff  <= '0;
         bcnt_ff  <= '0;
         peak_ff  <= '0;
         last_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         if (cmd.load_out) ov_ff <= 1'b1;
         else if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (cfg_hit) begin
            if (csr_index == REG_FRAME_COUNT) fc_ff <= csr_wdata;
            else cc_ff <= csr_wdata[CHAN_W-1:0];
            chpos_ff <= '0;
            fpos_ff  <= '0;
            cb_ff    <= '0;
            bend_ff  <= (fc_new >= BINS_F) ? (fc_new >> LOG_BINS) :
                        (fc_new == '0) ? '0 : FRAME_W'(1);
            min_ff   <= Q_ONE;
            max_ff   <= Q_NEG_ONE;
            bsum_ff  <= '0;
            csum_ff  <= '0;
            bcnt_ff  <= '0;
            peak_ff  <= '0;
         end else if (cmd.accumulate && status.active) begin
            if (x_ff < min_ff) min_ff <= x_ff;
            if (x_ff > max_ff) max_ff <= x_ff;
            bsum_ff <= bsum_add[SUM_W] ? '1 : bsum_add[SUM_W-1:0];
            csum_ff <= csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
            bcnt_ff <= bcnt_ff + 1'b1;
            if (mag_ff > peak_ff) peak_ff <= mag_ff;
            last_ff <= (32'(cb_next) >= nb) || (fpos_next >= fc_ff);
            if (frame_wrap) begin
               chpos_ff <= '0;
               fpos_ff  <= fpos_next;
            end else begin
               chpos_ff <= chpos_next[CHPOS_W-1:0];
            end
         end else if (cmd.load_out) begin
            min_ff  <= Q_ONE;
            max_ff  <= Q_NEG_ONE;
            bsum_ff <= '0;
            bcnt_ff <= '0;
            if (last_ff) begin
               chpos_ff <= '0;
               fpos_ff  <= '0;
               cb_ff    <= '0;
               bend_ff  <= (fc_ff >= BINS_F) ? (fc_ff >> LOG_BINS) : FRAME_W'(1);
               csum_ff  <= '0;
               peak_ff  <= '0;
            end else begin
               cb_ff   <= cb_next;
               bend_ff <= bend_next;
            end
         end
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_bin_index = oidx_ff;
   assign rsp_bin_min   = omin_ff;
   assign rsp_bin_max   = omax_ff;
   assign rsp_bin_rms   = orms_ff;
   assign rsp_last_bin  = olast_ff;
   assign rsp_clip_peak = opeak_ff;
   assign rsp_clip_rms  = ocrms_ff;

endmodule

// File: hw/rtl/waveform_overview_min_max_rms_top.sv
// Sequence: an accepted item is captured, then accumulated; an item closing a
//   bin runs the RMS divide and square root, again for the clip RMS on the clip's
//   final bin. Items are taken one at a time: the 64-step divider and 24-step
//   square root, shared by bin and clip RMS, hold off input while they run.
// Reset: synchronous, active high; frame_count = 1, channel_count = 1.
// ----------------------------------------------------------------------------
// waveform_overview_min_max_rms_top
// Per-bin min/max/RMS decimator with whole-clip peak and RMS.
// ----------------------------------------------------------------------------
module waveform_overview_min_max_rms_top #(
   parameter int BINS = wfo_pkg::BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wfo_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wfo_pkg::INDEX_W-1:0]           rsp_bin_index,
   output logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_min,
   output logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_max,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_bin_rms,
   output logic                                  rsp_last_bin,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_peak,
   output logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_rms,
   input  logic                                  csr_write,
   input  logic [wfo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wfo_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import wfo_pkg::*;

   cmd_type    cmd;
   status_type status;

   wfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wfo_datapath #(.BINS(BINS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_sample),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_min   (rsp_bin_min),
      .rsp_bin_max   (rsp_bin_max),
      .rsp_bin_rms   (rsp_bin_rms),
      .rsp_last_bin  (rsp_last_bin),
      .rsp_clip_peak (rsp_clip_peak),
      .rsp_clip_rms  (rsp_clip_rms)
   );

endmodule

// File: hw/rtl/wfo_checker.sv
// ----------------------------------------------------------------------------
// wfo_checker
// Port-level checks on the overview results, bound to the top level.
// ----------------------------------------------------------------------------
module wfo_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [wfo_pkg::INDEX_W-1:0]         rsp_bin_index,
   input logic signed [wfo_pkg::MINMAX_W-1:0] rsp_bin_min,
   input logic signed [wfo_pkg::MINMAX_W-1:0] rsp_bin_max,
   input logic [wfo_pkg::LEVEL_W-1:0]         rsp_bin_rms,
   input logic                                rsp_last_bin,
   input logic [wfo_pkg::LEVEL_W-1:0]         rsp_clip_peak,
   input logic [wfo_pkg::LEVEL_W-1:0]         rsp_clip_rms
);
   import wfo_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index)
         && $stable(rsp_bin_rms))
      else $error("stalled item changed");

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |-> rsp_clip_peak == '0 && rsp_clip_rms == '0)
      else $error("clip fields set on a non-final bin");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin_min <= rsp_bin_max)
      else $error("bin min above bin max");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin_rms <= 24'd8388608 && rsp_clip_rms <= 24'd8388608)
      else $error("rms above full scale");

endmodule

bind waveform_overview_min_max_rms_top wfo_checker u_wfo_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bin_index (rsp_bin_index),
   .rsp_bin_min   (rsp_bin_min),
   .rsp_bin_max   (rsp_bin_max),
   .rsp_bin_rms   (rsp_bin_rms),
   .rsp_last_bin  (rsp_last_bin),
   .rsp_clip_peak (rsp_clip_peak),
   .rsp_clip_rms  (rsp_clip_rms)
);

// File: sim/wfo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfo_scoreboard
// Watches the sample, bin and register ports of the waveform overview block.
// It keeps its own copy of the clip state, works out the bin summary that each
// accepted sample closes, and compares every delivered bin field by field.
// ----------------------------------------------------------------------------
module wfo_scoreboard #(
   parameter int BINS = wfo_pkg::BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [wfo_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [wfo_pkg::INDEX_W-1:0]           rsp_bin_index,
   input  logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_min,
   input  logic signed [wfo_pkg::MINMAX_W-1:0]   rsp_bin_max,
   input  logic [wfo_pkg::LEVEL_W-1:0]           rsp_bin_rms,
   input  logic                                  rsp_last_bin,
   input  logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_peak,
   input  logic [wfo_pkg::LEVEL_W-1:0]           rsp_clip_rms,
   input  logic                                  csr_write,
   input  logic [wfo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wfo_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                    fail_count,
   output int                                    pending
);
   import wfo_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0]         index;
      logic signed [MINMAX_W-1:0] low;
      logic signed [MINMAX_W-1:0] high;
      logic [LEVEL_W-1:0]         rms;
      logic                       last;
      logic [LEVEL_W-1:0]         peak;
      logic [LEVEL_W-1:0]         clip_rms;
   } bin_summary_type;

   bin_summary_type bins_due[$];

   logic [FRAME_W-1:0]         frames;
   logic [CHAN_W-1:0]          chans;
   logic [CHAN_W-1:0]          chan_pos;
   logic [FRAME_W-1:0]         frame_pos;
   logic [31:0]                bin_no;
   logic [FRAME_W-1:0]         bin_stop;
   logic signed [MINMAX_W-1:0] low_run;
   logic signed [MINMAX_W-1:0] high_run;
   logic [SUM_W-1:0]           bin_energy;
   logic [COUNT_W-1:0]         bin_samples;
   logic [LEVEL_W-1:0]         peak_run;
   logic [SUM_W-1:0]           clip_energy;

   function automatic logic [CHAN_W-1:0] live_chans(input logic [CHAN_W-1:0] c);
      if (c == '0) return CHAN_W'(1);
      if (c > MAX_CHANNELS) return MAX_CHANNELS;
      return c;
   endfunction

   function automatic logic [31:0] bin_span(input logic [FRAME_W-1:0] f);
      return (f < BINS) ? f : BINS;
   endfunction

   function automatic logic [FRAME_W-1:0] bin_edge(input logic [31:0] b,
                                                   input logic [FRAME_W-1:0] f);
      logic [63:0] prod;
      if (bin_span(f) == 0) return '0;
      prod = ({32'd0, b} + 64'd1) * {32'd0, f};
      return FRAME_W'(prod / {32'd0, bin_span(f)});
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [LEVEL_W-1:0] rms_level(input logic [63:0] energy,
                                                    input logic [63:0] count);
      logic [63:0] mean;
      logic [63:0] r;
      if (count == 0) return '0;
      mean = energy / count;
      if (mean > (64'd1 << 32)) mean = 64'd1 << 32;
      r = int_sqrt(mean << 14);
      if (r > 64'd8388608) r = 64'd8388608;
      return LEVEL_W'(r);
   endfunction

   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   task automatic open_bin();
      low_run = Q_ONE;
      high_run = Q_NEG_ONE;
      bin_energy = '0;
      bin_samples = '0;
   endtask

   task automatic open_clip();
      chan_pos = '0;
      frame_pos = '0;
      bin_no = '0;
      bin_stop = bin_edge(32'd0, frames);
      open_bin();
      peak_run = '0;
      clip_energy = '0;
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   task automatic predict_sample(input logic signed [SAMPLE_W-1:0] s);
      logic signed [MINMAX_W-1:0] x;
      logic [LEVEL_W-1:0]         mag;
      logic [63:0]                sq;
      logic                       fin;
      bin_summary_type            e;
      if (frames == 0) return;
      x = s;
      mag = (x < 0) ? LEVEL_W'(-x) : LEVEL_W'(x);
      if (x < low_run) low_run = x;
      if (x > high_run) high_run = x;
      sq = ({40'd0, mag} * {40'd0, mag}) >> 14;
      bin_energy = add_clamped(bin_energy, sq);
      clip_energy = add_clamped(clip_energy, sq);
      bin_samples++;
      if (mag > peak_run) peak_run = mag;
      chan_pos++;
      if (chan_pos < live_chans(chans)) return;
      chan_pos = '0;
      frame_pos++;
      if (frame_pos != bin_stop) return;
      fin = (bin_no + 1 >= bin_span(frames)) || (frame_pos >= frames);
      e.index = bin_no[INDEX_W-1:0];
      e.low = low_run;
      e.high = high_run;
      e.rms = rms_level(bin_energy, {26'd0, bin_samples});
      e.last = fin;
      e.peak = '0;
      e.clip_rms = '0;
      if (fin) begin
         e.peak = peak_run;
         e.clip_rms = rms_level(clip_energy, {32'd0, frames} * live_chans(chans));
         bins_due = {bins_due, e};
         open_clip();
      end else begin
         bins_due = {bins_due, e};
         bin_no++;
         bin_stop = bin_edge(bin_no, frames);
         open_bin();
      end
   endtask

   always @(posedge clock) begin
      bin_summary_type w;
      if (reset) begin
         frames = FRAME_W'(1);
         chans = CHAN_W'(1);
         open_clip();
         bins_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bins_due.size() == 0) begin
               report("unexpected bin", rsp_bin_index, 64'd0);
            end else begin
               w = bins_due.pop_front();
               if (rsp_bin_index !== w.index) report("bin_index", rsp_bin_index, w.index);
               if (rsp_bin_min !== w.low) report("bin_min", rsp_bin_min, w.low);
               if (rsp_bin_max !== w.high) report("bin_max", rsp_bin_max, w.high);
               if (rsp_bin_rms !== w.rms) report("bin_rms", rsp_bin_rms, w.rms);
               if (rsp_last_bin !== w.last) report("last_bin", rsp_last_bin, w.last);
               if (rsp_clip_peak !== w.peak) report("clip_peak", rsp_clip_peak, w.peak);
               if (rsp_clip_rms !== w.clip_rms) report("clip_rms", rsp_clip_rms, w.clip_rms);
            end
         end
         if (csr_write) begin
            if (csr_index == REG_FRAME_COUNT) begin
               frames = csr_wdata;
               open_clip();
            end else if (csr_index == REG_CHANNEL_COUNT) begin
               chans = csr_wdata[CHAN_W-1:0];
               open_clip();
            end
         end
         if (req_valid && req_ready) predict_sample(req_sample);
      end
      pending <= bins_due.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples and register writes into the waveform overview block with
// bursty input and a stalling bin receiver; the scoreboard predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import wfo_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd2;

   logic                        clock = 0;
   logic                        reset = 1;
   logic                        req_valid = 0;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample = 0;
   logic                        rsp_valid;
   logic                        rsp_ready = 0;
   logic [INDEX_W-1:0]          rsp_bin_index;
   logic signed [MINMAX_W-1:0]  rsp_bin_min;
   logic signed [MINMAX_W-1:0]  rsp_bin_max;
   logic [LEVEL_W-1:0]          rsp_bin_rms;
   logic                        rsp_last_bin;
   logic [LEVEL_W-1:0]          rsp_clip_peak;
   logic [LEVEL_W-1:0]          rsp_clip_rms;
   logic                        csr_write = 0;
   logic [CSR_IDX_W-1:0]        csr_index = 0;
   logic [CSR_DATA_W-1:0]       csr_wdata = 0;
   int                          fail_count;
   int                          pending;

   int  burst_left = 0;
   bit  hold_asked = 0;
   int  random_items = 0;

   always #5 clock = ~clock;

   waveform_overview_min_max_rms_top dut (.*);

   wfo_scoreboard u_scoreboard (.*);

   initial begin
      #10ms;
      $display("testbench: errors");
      $finish;
   end

   // receiver: randomly chosen ready modes, long hold on request
   initial begin
      int mode;
      int cyc;
      int hold_cycles;
      bit held;
      mode = 0;
      cyc = 0;
      hold_cycles = 0;
      held = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 2);
         if (hold_asked && !held) begin
            held = 1;
            hold_cycles = 2000;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return -24'sd8388608;
         1: return 24'sd8388607;
         2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int fc;
      int ch;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default one-frame mono clip: each sample is a whole clip
      send_item(-24'sd8388608);
      send_item(24'sd8388607);
      send_item(24'sd0);
      send_item(-24'sd1);
      write_reg(REG_CHANNEL_COUNT, 32'd0);
      write_reg(REG_FRAME_COUNT, 32'd3);
      send_item(24'sd1);
      send_item(24'sd8388607);
      send_item(-24'sd8388608);
      write_reg(REG_CHANNEL_COUNT, 32'd127);
      write_reg(REG_FRAME_COUNT, 32'd1);
      repeat (64) send_item(pick_sample());
      write_reg(REG_FRAME_COUNT, 32'd0);
      repeat (5) send_item(pick_sample());
      write_reg(REG_CHANNEL_COUNT, 32'd1);
      write_reg(REG_FRAME_COUNT, 32'hFFFF_FFFF);
      repeat (5) send_item(pick_sample());
      write_reg(REG_UNUSED, 32'h1234_5678);
      write_reg(REG_FRAME_COUNT, 32'd256);

      // receiver held off while a 256-bin clip streams in
      drain();
      hold_asked = 1;
      burst_left = 1000;
      repeat (256) send_item(pick_sample());
      burst_left = 0;

      while (random_items < 360) begin
         if ($urandom_range(0, 9) != 0) begin
            fc = $urandom_range(1, 40);
            ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 3);
            if (ch > 8 && fc > 4) fc = $urandom_range(1, 4);
         end else begin
            fc = $urandom_range(257, 520);
            ch = 1;
         end
         write_reg(REG_FRAME_COUNT, fc);
         write_reg(REG_CHANNEL_COUNT, ch);
         if (ch == 0) ch = 1;
         if (ch > 64) ch = 64;
         n = fc * ch;
         if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
         repeat (n) send_item(pick_sample());
         random_items += n;
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/wfo_pkg.sv
hw/rtl/wfo_ctrl.sv
hw/rtl/wfo_datapath.sv
hw/rtl/waveform_overview_min_max_rms_top.sv
hw/rtl/wfo_checker.sv
sim/wfo_checker.sv
sim/testbench.sv
